>>> design/spi_pkg.sv
// Package: widths, status codes and shared payload types for the segment/plane core.
package spi_pkg;
   localparam int FRAC_BITS = 16;
   localparam int COORD_W = 32;
   localparam int PROD_W = 2 * COORD_W;
   localparam int VAL_W = PROD_W - FRAC_BITS + 2;
   localparam int REM_W = VAL_W + 1;
   localparam int DIR_W = COORD_W + 1;
   localparam int T_W = COORD_W + 1;
   localparam int DIV_STAGES = T_W;
   localparam int CSR_IDX_W = 4;

   typedef enum logic [1:0] {
      STATUS_CROSS = 2'd0,
      STATUS_ON_PLANE = 2'd1,
      STATUS_SAME_SIDE = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NORMAL_X = 4'd0,
      CSR_NORMAL_Y = 4'd1,
      CSR_NORMAL_Z = 4'd2,
      CSR_OFFSET = 4'd3
   } csr_index_type;

   typedef struct packed {
      logic signed [2:0][COORD_W-1:0] start;
      logic signed [2:0][DIR_W-1:0] dir;
      status_type status;
   } carry_type;
endpackage

>>> design/spi_if.sv
// Interfaces: request (segment) and response (intersection) channels.
interface spi_req_if;
   logic valid;
   logic ready;
   logic signed [31:0] start_x;
   logic signed [31:0] start_y;
   logic signed [31:0] start_z;
   logic signed [31:0] end_x;
   logic signed [31:0] end_y;
   logic signed [31:0] end_z;
   modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z, input ready);
   modport sink (input valid, start_x, start_y, start_z, end_x, end_y, end_z, output ready);
endinterface

interface spi_rsp_if;
   logic valid;
   logic ready;
   logic hit;
   logic [1:0] status;
   logic signed [31:0] cross_x;
   logic signed [31:0] cross_y;
   logic signed [31:0] cross_z;
   modport source (output valid, hit, status, cross_x, cross_y, cross_z, input ready);
   modport sink (input valid, hit, status, cross_x, cross_y, cross_z, output ready);
endinterface

>>> design/segment_plane_intersect_core.sv
// Top level: segment/plane intersection core with plane registers and pipeline.
//
// Usage: a segment (start and end points, signed Q16.16) enters on req_chan;
// one result per segment leaves on rsp_chan with hit, status and the crossing
// point. The plane (normal, offset) is written through the csr_ port: index 0..2
// normal x/y/z, index 3 offset; other indexes are ignored. Write only while idle.
// Stages: 3 plane-evaluation stages, 33 divider stages at one quotient bit each,
// and 2 point stages, from accepted request to result valid.
// Throughput: one transaction per cycle; the whole pipeline advances whenever
// the output register is empty or being taken.
// Stall: when rsp_chan.ready is low with a result waiting, every stage holds
// and req_chan.ready drops; nothing is lost or repeated.
// Reset: pipeline emptied, normal = (0, 0, 1.0), offset = 0.
module segment_plane_intersect_core (
   input  logic clock,
   input  logic reset,
   spi_req_if.sink req_chan,
   spi_rsp_if.source rsp_chan,
   input  logic csr_write,
   input  logic [spi_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [spi_pkg::COORD_W-1:0] csr_wdata
);
   logic signed [2:0][spi_pkg::COORD_W-1:0] normal_ff;
   logic signed [spi_pkg::COORD_W-1:0] offset_ff;
   logic advance;
   logic p_valid, d_valid;
   logic [spi_pkg::VAL_W-1:0] num, den;
   logic [spi_pkg::T_W-1:0] quot;
   spi_pkg::carry_type p_carry, d_carry;
   spi_pkg::status_type status;
   logic signed [2:0][spi_pkg::COORD_W-1:0] start, stop, point;

   assign advance = !rsp_chan.valid || rsp_chan.ready;
   assign req_chan.ready = advance;
   assign start = {req_chan.start_z, req_chan.start_y, req_chan.start_x};
   assign stop = {req_chan.end_z, req_chan.end_y, req_chan.end_x};

   always_ff @(posedge clock) begin
      if (reset) begin
         normal_ff <= {spi_pkg::COORD_W'(1) << spi_pkg::FRAC_BITS, spi_pkg::COORD_W'(0),
                       spi_pkg::COORD_W'(0)};
         offset_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            spi_pkg::CSR_NORMAL_X: normal_ff[0] <= csr_wdata;
            spi_pkg::CSR_NORMAL_Y: normal_ff[1] <= csr_wdata;
            spi_pkg::CSR_NORMAL_Z: normal_ff[2] <= csr_wdata;
            spi_pkg::CSR_OFFSET: offset_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   spi_plane u_plane (
      .clock, .reset, .advance,
      .in_valid(req_chan.valid), .start, .stop,
      .normal(normal_ff), .offset(offset_ff),
      .out_valid(p_valid), .num, .den, .out_carry(p_carry)
   );

   spi_div u_div (
      .clock, .reset, .advance,
      .in_valid(p_valid), .num, .den, .in_carry(p_carry),
      .out_valid(d_valid), .quot, .out_carry(d_carry)
   );

   spi_point u_point (
      .clock, .reset, .advance,
      .in_valid(d_valid), .quot, .in_carry(d_carry),
      .out_valid(rsp_chan.valid), .out_hit(rsp_chan.hit),
      .out_status(status), .out_point(point)
   );

   assign rsp_chan.status = status;
   assign rsp_chan.cross_x = point[0];
   assign rsp_chan.cross_y = point[1];
   assign rsp_chan.cross_z = point[2];
endmodule

>>> design/spi_plane.sv
// Plane evaluation: products, plane values, classification and divider operands.
module spi_plane (
   input  logic clock,
   input  logic reset,
   input  logic advance,
   input  logic in_valid,
   input  logic signed [2:0][spi_pkg::COORD_W-1:0] start,
   input  logic signed [2:0][spi_pkg::COORD_W-1:0] stop,
   input  logic signed [2:0][spi_pkg::COORD_W-1:0] normal,
   input  logic signed [spi_pkg::COORD_W-1:0] offset,
   output logic out_valid,
   output logic [spi_pkg::VAL_W-1:0] num,
   output logic [spi_pkg::VAL_W-1:0] den,
   output spi_pkg::carry_type out_carry
);
   logic [2:0] valid_ff, valid_in;
   logic signed [2:0][spi_pkg::PROD_W-1:0] pa_ff, pa_in, pb_ff, pb_in;
   logic signed [spi_pkg::VAL_W-1:0] da_ff, da_in, db_ff, db_in;
   spi_pkg::carry_type c1_ff, c1_in, c2_ff, c3_ff, c3_in;
   logic [spi_pkg::VAL_W-1:0] num_ff, num_in, den_ff, den_in;
   logic [spi_pkg::VAL_W-1:0] nb;

   always_comb begin
      valid_in = {valid_ff[1:0], in_valid};
      c1_in = '0;
      for (int c = 0; c < 3; c++) begin
         pa_in[c] = spi_pkg::PROD_W'($signed(normal[c])) * spi_pkg::PROD_W'($signed(start[c]));
         pb_in[c] = spi_pkg::PROD_W'($signed(normal[c])) * spi_pkg::PROD_W'($signed(stop[c]));
         c1_in.start[c] = start[c];
         c1_in.dir[c] = spi_pkg::DIR_W'($signed(stop[c])) - spi_pkg::DIR_W'($signed(start[c]));
      end
      da_in = spi_pkg::VAL_W'(offset);
      db_in = spi_pkg::VAL_W'(offset);
      for (int c = 0; c < 3; c++) begin
         da_in = da_in + spi_pkg::VAL_W'($signed(pa_ff[c][spi_pkg::PROD_W-1:spi_pkg::FRAC_BITS]));
         db_in = db_in + spi_pkg::VAL_W'($signed(pb_ff[c][spi_pkg::PROD_W-1:spi_pkg::FRAC_BITS]));
      end
      num_in = da_ff[spi_pkg::VAL_W-1] ? spi_pkg::VAL_W'(-da_ff) : spi_pkg::VAL_W'(da_ff);
      nb = db_ff[spi_pkg::VAL_W-1] ? spi_pkg::VAL_W'(-db_ff) : spi_pkg::VAL_W'(db_ff);
      den_in = num_in + nb;
      c3_in = c2_ff;
      if (da_ff == '0 && db_ff == '0) begin
         c3_in.status = spi_pkg::STATUS_ON_PLANE;
      end else if (da_ff[spi_pkg::VAL_W-1] == db_ff[spi_pkg::VAL_W-1] && da_ff != '0
                   && db_ff != '0) begin
         c3_in.status = spi_pkg::STATUS_SAME_SIDE;
      end else begin
         c3_in.status = spi_pkg::STATUS_CROSS;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pa_ff <= pa_in;
         pb_ff <= pb_in;
         c1_ff <= c1_in;
         da_ff <= da_in;
         db_ff <= db_in;
         c2_ff <= c1_ff;
         num_ff <= num_in;
         den_ff <= den_in;
         c3_ff <= c3_in;
      end
   end

   assign out_valid = valid_ff[2];
   assign num = num_ff;
   assign den = den_ff;
   assign out_carry = c3_ff;
endmodule

>>> design/spi_div.sv
// Pipelined restoring divider: one quotient bit per stage, t = floor(num * 2^32 / den).
module spi_div (
   input  logic clock,
   input  logic reset,
   input  logic advance,
   input  logic in_valid,
   input  logic [spi_pkg::VAL_W-1:0] num,
   input  logic [spi_pkg::VAL_W-1:0] den,
   input  spi_pkg::carry_type in_carry,
   output logic out_valid,
   output logic [spi_pkg::T_W-1:0] quot,
   output spi_pkg::carry_type out_carry
);
   localparam int N = spi_pkg::DIV_STAGES;
   logic [N-1:0] valid_ff;
   logic [N-1:0][spi_pkg::REM_W-1:0] rem_ff, rem_in;
   logic [N-1:0][spi_pkg::VAL_W-1:0] den_ff;
   logic [N-1:0][spi_pkg::T_W-1:0] q_ff, q_in;
   spi_pkg::carry_type carry_ff [N];

   for (genvar k = 0; k < N; k++) begin : g_step
      logic [spi_pkg::REM_W-1:0] rs;
      logic [spi_pkg::REM_W-1:0] dd;
      logic ge;
      if (k == 0) begin : g_first
         assign rs = spi_pkg::REM_W'(num);
         assign dd = spi_pkg::REM_W'(den);
      end else begin : g_next
         assign rs = {rem_ff[k-1][spi_pkg::REM_W-2:0], 1'b0};
         assign dd = spi_pkg::REM_W'(den_ff[k-1]);
      end
      assign ge = rs >= dd;
      assign rem_in[k] = ge ? rs - dd : rs;
      if (k == 0) begin : g_q0
         assign q_in[k] = spi_pkg::T_W'(ge);
      end else begin : g_qn
         assign q_in[k] = {q_ff[k-1][spi_pkg::T_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[N-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff <= rem_in;
         q_ff <= q_in;
         den_ff[0] <= den;
         carry_ff[0] <= in_carry;
         for (int k = 1; k < N; k++) begin
            den_ff[k] <= den_ff[k-1];
            carry_ff[k] <= carry_ff[k-1];
         end
      end
   end

   assign out_valid = valid_ff[N-1];
   assign quot = q_ff[N-1];
   assign out_carry = carry_ff[N-1];
endmodule

>>> design/spi_point.sv
// Crossing point: |dir| * t rounded, applied to start with saturation; output register.
module spi_point (
   input  logic clock,
   input  logic reset,
   input  logic advance,
   input  logic in_valid,
   input  logic [spi_pkg::T_W-1:0] quot,
   input  spi_pkg::carry_type in_carry,
   output logic out_valid,
   output logic out_hit,
   output spi_pkg::status_type out_status,
   output logic signed [2:0][spi_pkg::COORD_W-1:0] out_point
);
   localparam int CW = spi_pkg::COORD_W;
   localparam int PW = spi_pkg::DIR_W + CW;
   logic [1:0] valid_ff;
   logic [2:0][PW-1:0] prod_ff, prod_in;
   logic [2:0][spi_pkg::DIR_W-1:0] mag_ff, mag_in;
   logic thi_ff;
   spi_pkg::carry_type carry_ff;
   logic signed [2:0][CW-1:0] point_ff, point_in;
   logic hit_ff, hit_in;
   spi_pkg::status_type status_ff;
   logic [PW:0] sum;
   logic signed [CW+3:0] p;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         mag_in[c] = in_carry.dir[c][spi_pkg::DIR_W-1] ? spi_pkg::DIR_W'(-in_carry.dir[c])
                                                      : in_carry.dir[c];
         prod_in[c] = PW'(mag_in[c]) * PW'(quot[CW-1:0]);
      end
      hit_in = carry_ff.status == spi_pkg::STATUS_CROSS;
      sum = '0;
      p = '0;
      for (int c = 0; c < 3; c++) begin
         sum = (PW+1)'(prod_ff[c]) + ((PW+1)'(1) << (CW-1));
         if (thi_ff) begin
            sum = sum + ((PW+1)'(mag_ff[c]) << CW);
         end
         if (carry_ff.dir[c][spi_pkg::DIR_W-1]) begin
            p = (CW+4)'($signed(carry_ff.start[c])) - (CW+4)'(sum[PW:CW]);
         end else begin
            p = (CW+4)'($signed(carry_ff.start[c])) + (CW+4)'(sum[PW:CW]);
         end
         if (!hit_in) begin
            point_in[c] = '0;
         end else if (p > (CW+4)'(32'sh7fffffff)) begin
            point_in[c] = 32'sh7fffffff;
         end else if (p < -(CW+4)'(33'sh080000000)) begin
            point_in[c] = 32'sh80000000;
         end else begin
            point_in[c] = CW'(p);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= prod_in;
         mag_ff <= mag_in;
         thi_ff <= quot[CW];
         carry_ff <= in_carry;
         point_ff <= point_in;
         hit_ff <= hit_in;
         status_ff <= carry_ff.status;
      end
   end

   assign out_valid = valid_ff[1];
   assign out_hit = hit_ff;
   assign out_status = status_ff;
   assign out_point = point_ff;
endmodule

>>> design/spi_checker.sv
// Port checker for the segment/plane core, bound to the top level.
module spi_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_hit,
   input logic [1:0] rsp_status,
   input logic [31:0] rsp_cross_x,
   input logic [31:0] rsp_cross_y,
   input logic [31:0] rsp_cross_z
);
   a_hit_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_hit == (rsp_status == spi_pkg::STATUS_CROSS)))
      else $error("hit disagrees with status");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status != 2'd3))
      else $error("undefined status code");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit) |->
         (rsp_cross_x == '0 && rsp_cross_y == '0 && rsp_cross_z == '0))
      else $error("nonzero point without hit");

   a_reset_empty: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !rsp_valid)
      else $error("response valid right after reset");

   a_stall_ready: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("request taken while output stalled");
endmodule

bind segment_plane_intersect_core spi_checker u_spi_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_chan.valid),
   .req_ready(req_chan.ready),
   .rsp_valid(rsp_chan.valid),
   .rsp_ready(rsp_chan.ready),
   .rsp_hit(rsp_chan.hit),
   .rsp_status(rsp_chan.status),
   .rsp_cross_x(rsp_chan.cross_x),
   .rsp_cross_y(rsp_chan.cross_y),
   .rsp_cross_z(rsp_chan.cross_z)
);

>>> verif/testbench.sv
// Testbench: random and directed segments against several planes, checked against a predictor.
module testbench;
   localparam int LIMIT_CYCLES = 600000;
   localparam int DRAIN_CYCLES = 45;
   localparam int ITEMS_PER_PLANE = 150;

   typedef struct {
      logic signed [31:0] sx, sy, sz, ex, ey, ez;
   } segment_type;

   typedef struct {
      logic hit;
      spi_pkg::status_type status;
      logic signed [31:0] x, y, z;
   } crossing_type;

   logic clock = 0;
   logic reset = 1;
   logic csr_write = 0;
   logic [spi_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [spi_pkg::COORD_W-1:0] csr_wdata = '0;

   spi_req_if req_chan ();
   spi_rsp_if rsp_chan ();

   segment_plane_intersect_core dut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   logic signed [31:0] plane_nx = 0, plane_ny = 0, plane_nz = 65536, plane_d = 0;
   segment_type pending_segments[$];
   crossing_type expected_crossings[$];
   logic sent = 0;
   logic quiet = 0;
   logic pressure_done = 0;
   int gap = 0;
   int hold = 0;
   int errors = 0;
   int accepted = 0;
   int hits = 0;
   int cycles = 0;

   initial begin
      req_chan.valid = 0;
      req_chan.start_x = 0; req_chan.start_y = 0; req_chan.start_z = 0;
      req_chan.end_x = 0; req_chan.end_y = 0; req_chan.end_z = 0;
      rsp_chan.ready = 0;
      forever #1 clock = ~clock;
   end

   function automatic longint plane_eval(logic signed [31:0] x, logic signed [31:0] y,
                                         logic signed [31:0] z);
      longint px, py, pz;
      px = (longint'(plane_nx) * longint'(x)) >>> spi_pkg::FRAC_BITS;
      py = (longint'(plane_ny) * longint'(y)) >>> spi_pkg::FRAC_BITS;
      pz = (longint'(plane_nz) * longint'(z)) >>> spi_pkg::FRAC_BITS;
      return px + py + pz + longint'(plane_d);
   endfunction

   function automatic logic signed [31:0] cross_coord(logic signed [31:0] s,
                                                      logic signed [31:0] e,
                                                      logic [127:0] t);
      longint d, p;
      logic [127:0] ad, q;
      d = longint'(e) - longint'(s);
      ad = d < 0 ? 128'(-d) : 128'(d);
      q = (ad * t + 128'h8000_0000) >> 32;
      p = d < 0 ? longint'(s) - longint'(q[63:0]) : longint'(s) + longint'(q[63:0]);
      if (p > 64'sd2147483647) p = 64'sd2147483647;
      if (p < -64'sd2147483648) p = -64'sd2147483648;
      return p[31:0];
   endfunction

   function automatic crossing_type predict_crossing(segment_type sg);
      crossing_type r;
      longint da, db;
      logic [127:0] na, nb, t;
      da = plane_eval(sg.sx, sg.sy, sg.sz);
      db = plane_eval(sg.ex, sg.ey, sg.ez);
      r.hit = 0; r.x = 0; r.y = 0; r.z = 0;
      if (da == 0 && db == 0) begin
         r.status = spi_pkg::STATUS_ON_PLANE;
      end else if ((da >= 0 && db <= 0) || (da <= 0 && db >= 0)) begin
         na = da < 0 ? 128'(-da) : 128'(da);
         nb = db < 0 ? 128'(-db) : 128'(db);
         t = (na << 32) / (na + nb);
         r.hit = 1;
         r.status = spi_pkg::STATUS_CROSS;
         r.x = cross_coord(sg.sx, sg.ex, t);
         r.y = cross_coord(sg.sy, sg.ey, t);
         r.z = cross_coord(sg.sz, sg.ez, t);
      end else begin
         r.status = spi_pkg::STATUS_SAME_SIDE;
      end
      return r;
   endfunction

   function automatic logic signed [31:0] rand_coord(int mode);
      case (mode)
         0: return $urandom;
         1: return $signed($urandom_range(0, 32'h1F_FFFF)) - 32'sh10_0000;
         default: return $signed($urandom_range(0, 32'h7FF)) - 32'sh400;
      endcase
   endfunction

   function automatic segment_type rand_segment();
      segment_type sg;
      int mode;
      mode = $urandom_range(0, 2);
      sg.sx = rand_coord(mode); sg.sy = rand_coord(mode); sg.sz = rand_coord(mode);
      sg.ex = rand_coord(mode); sg.ey = rand_coord(mode); sg.ez = rand_coord(mode);
      case ($urandom_range(0, 9))
         0: begin sg.ex = sg.sx; sg.ey = sg.sy; sg.ez = sg.sz; end
         1: sg.ez = 0;
         2: begin sg.sz = 0; sg.ez = 0; end
         3: sg.sx = 0;
         default: ;
      endcase
      return sg;
   endfunction

   function automatic segment_type make_segment(int sx, int sy, int sz, int ex, int ey, int ez);
      segment_type sg;
      sg.sx = sx; sg.sy = sy; sg.sz = sz; sg.ex = ex; sg.ey = ey; sg.ez = ez;
      return sg;
   endfunction

   task automatic write_csr(spi_pkg::csr_index_type idx, logic signed [31:0] value);
      @(negedge clock);
      csr_write <= 1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_write <= 0;
      case (idx)
         spi_pkg::CSR_NORMAL_X: plane_nx = value;
         spi_pkg::CSR_NORMAL_Y: plane_ny = value;
         spi_pkg::CSR_NORMAL_Z: plane_nz = value;
         spi_pkg::CSR_OFFSET: plane_d = value;
         default: ;
      endcase
   endtask

   task automatic set_plane(logic signed [31:0] nx, logic signed [31:0] ny,
                            logic signed [31:0] nz, logic signed [31:0] d);
      write_csr(spi_pkg::CSR_NORMAL_X, nx);
      write_csr(spi_pkg::CSR_NORMAL_Y, ny);
      write_csr(spi_pkg::CSR_NORMAL_Z, nz);
      write_csr(spi_pkg::CSR_OFFSET, d);
   endtask

   task automatic drain();
      while (pending_segments.size() != 0 || req_chan.valid || expected_crossings.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic queue_random(int n);
      repeat (n) pending_segments.push_back(rand_segment());
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // reset plane is z = 0
      pending_segments.push_back(make_segment(0, 0, 65536, 0, 0, -65536));
      pending_segments.push_back(make_segment(5, 7, 0, -9, 3, 0));
      pending_segments.push_back(make_segment(1, 2, 3, 4, 5, 6));
      pending_segments.push_back(make_segment(1, 2, -3, 4, 5, -6));
      pending_segments.push_back(make_segment(100, 200, 65536, 300, 400, 0));
      pending_segments.push_back(make_segment(100, 200, 0, 300, 400, -65536));
      pending_segments.push_back(make_segment(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                                              32'h80000000, 32'h7FFFFFFF, 32'h80000000));
      pending_segments.push_back(make_segment(32'h80000000, 32'h80000000, 32'h80000000,
                                              32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF));
      pending_segments.push_back(make_segment(32'h7FFFFFFF, 0, 1, 32'h80000000, 0, -1));
      pending_segments.push_back(make_segment(0, 0, 0, 0, 0, 0));
      pending_segments.push_back(make_segment(-1, -1, -1, -1, -1, -1));
      pending_segments.push_back(make_segment(0, 0, -1, 0, 0, 1));
      drain();
      set_plane(0, 0, 0, 0);
      pending_segments.push_back(make_segment(1, 2, 3, -4, -5, -6));
      pending_segments.push_back(make_segment(32'h7FFFFFFF, 0, 0, 0, 0, 32'h80000000));
      drain();
      set_plane(0, 0, 0, 12345);
      pending_segments.push_back(make_segment(1, 2, 3, -4, -5, -6));
      queue_random(40);
      drain();
      set_plane(0, 0, 65536, 0);
      queue_random(ITEMS_PER_PLANE);
      drain();
      set_plane(65536, 0, 0, -(5 << 16));
      queue_random(ITEMS_PER_PLANE);
      drain();
      set_plane(0, -65536, 0, 32'h7FFFFFFF);
      queue_random(ITEMS_PER_PLANE);
      drain();
      set_plane(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000);
      queue_random(ITEMS_PER_PLANE);
      drain();
      set_plane(32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF);
      queue_random(ITEMS_PER_PLANE);
      drain();
      set_plane(46341, 46341, 0, 1000);
      queue_random(ITEMS_PER_PLANE);
      repeat (4) begin
         drain();
         set_plane($urandom, $urandom, $urandom, $urandom);
         queue_random(ITEMS_PER_PLANE);
      end
      drain();
      set_plane($urandom_range(0, 65536), 0, 65536 - $urandom_range(0, 65536),
                $signed($urandom_range(0, 32'hFFFF)) - 32'sh8000);
      quiet = 1;
      queue_random(ITEMS_PER_PLANE);
      drain();
      $display("%0d segments checked over 14 plane settings, %0d crossings, %0d mismatches",
               accepted, hits, errors);
      if (errors == 0)
         $display("segment_plane_intersect_core regression: pass");
      else
         $display("segment_plane_intersect_core regression: fail");
      $finish;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles", cycles);
         $display("segment_plane_intersect_core regression: fail");
         $finish;
      end
   end

   // driver
   always @(negedge clock) begin
      segment_type sg;
      sent <= 0;
      if (reset) begin
         req_chan.valid <= 0;
      end else if (!req_chan.valid || sent) begin
         if (gap > 0) begin
            gap <= gap - 1;
            req_chan.valid <= 0;
         end else if (pending_segments.size() != 0) begin
            sg = pending_segments.pop_front();
            req_chan.start_x <= sg.sx; req_chan.start_y <= sg.sy; req_chan.start_z <= sg.sz;
            req_chan.end_x <= sg.ex; req_chan.end_y <= sg.ey; req_chan.end_z <= sg.ez;
            req_chan.valid <= 1;
            if (!quiet && $urandom_range(0, 9) == 0) gap <= $urandom_range(1, 15);
         end else begin
            req_chan.valid <= 0;
         end
      end
   end

   always @(posedge clock) begin
      segment_type sg;
      if (!reset && req_chan.valid && req_chan.ready) begin
         sg.sx = req_chan.start_x; sg.sy = req_chan.start_y; sg.sz = req_chan.start_z;
         sg.ex = req_chan.end_x; sg.ey = req_chan.end_y; sg.ez = req_chan.end_z;
         expected_crossings.push_back(predict_crossing(sg));
         accepted <= accepted + 1;
         sent <= 1;
      end
   end

   // receiver stalls, with one long hold-off to back up the pipeline
   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 0;
      end else if (hold > 0) begin
         hold <= hold - 1;
         rsp_chan.ready <= 0;
      end else if (!pressure_done && accepted >= 300) begin
         pressure_done <= 1;
         hold <= 200;
         rsp_chan.ready <= 0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         hold <= $urandom_range(0, 14);
         rsp_chan.ready <= 0;
      end else begin
         rsp_chan.ready <= 1;
      end
   end

   // monitor
   always @(posedge clock) begin
      crossing_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_crossings.size() == 0) begin
            errors <= errors + 1;
            if (errors < 10) $display("unexpected transaction: hit %0b status %0d",
                                      rsp_chan.hit, rsp_chan.status);
         end else begin
            want = expected_crossings.pop_front();
            if (want.hit) hits <= hits + 1;
            if (rsp_chan.hit !== want.hit || rsp_chan.status !== want.status ||
                rsp_chan.cross_x !== want.x || rsp_chan.cross_y !== want.y ||
                rsp_chan.cross_z !== want.z) begin
               errors <= errors + 1;
               if (errors < 10)
                  $display("mismatch: exp %0b st %0d (%0d %0d %0d) got %0b %0d (%0d %0d %0d)",
                           want.hit, want.status, want.x, want.y, want.z, rsp_chan.hit,
                           rsp_chan.status, rsp_chan.cross_x, rsp_chan.cross_y,
                           rsp_chan.cross_z);
            end
         end
      end
   end
endmodule
